@@ rtl/bgot_pkg.sv @@
// Shared types, codes and the walk lookup for the glyph outline tracer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bgot_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_WALK_RD,
        ST_WALK_EV
    } t_state;

    // where the glyph trace stands between fetches
    typedef enum logic [1:0] {
        PH_NOMAP,
        PH_SCAN,
        PH_TRACE,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        HD_R,
        HD_D,
        HD_L,
        HD_U
    } t_heading;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // corner codes with a meaning of their own
    localparam logic [3:0] CODE_EMPTY = 4'h0;
    localparam logic [3:0] CODE_FULL  = 4'hF;
    localparam logic [3:0] CODE_OUTER = 4'h8;
    localparam logic [3:0] CODE_HOLE  = 4'h7;

    // point flag bits
    localparam logic [5:0] FLAG_BASE  = 6'o07;
    localparam logic [5:0] FLAG_XSAME = 6'o22;
    localparam logic [5:0] FLAG_YSAME = 6'o44;
    localparam logic [5:0] FLAG_XPOS  = 6'o20;
    localparam logic [5:0] FLAG_YPOS  = 6'o40;

    typedef struct packed {
        logic     hit;
        t_heading nd;
        logic [3:0] nc;
    } t_walk;

    // next heading and code left behind for a cell entered with heading hd
    function automatic t_walk walk_lookup(input t_heading hd, input logic [3:0] c);
        t_walk w;
        w.hit = 1'b1;
        w.nd  = hd;
        w.nc  = 4'h0;
        case (hd)
            HD_R: begin
                case (c)
                    4'd4:    w.nd = HD_D;
                    4'd6:    begin w.nd = HD_D; w.nc = 4'd2; end
                    4'd12:   w.nd = HD_R;
                    4'd14:   w.nd = HD_U;
                    default: w.hit = 1'b0;
                endcase
            end
            HD_D: begin
                case (c)
                    4'd1:    w.nd = HD_L;
                    4'd5:    w.nd = HD_D;
                    4'd9:    begin w.nd = HD_L; w.nc = 4'd8; end
                    4'd13:   w.nd = HD_R;
                    default: w.hit = 1'b0;
                endcase
            end
            HD_L: begin
                case (c)
                    4'd2:    w.nd = HD_U;
                    4'd3:    w.nd = HD_L;
                    4'd6:    begin w.nd = HD_U; w.nc = 4'd4; end
                    4'd7:    w.nd = HD_D;
                    default: w.hit = 1'b0;
                endcase
            end
            default: begin
                case (c)
                    4'd8:    w.nd = HD_R;
                    4'd9:    begin w.nd = HD_R; w.nc = 4'd1; end
                    4'd10:   w.nd = HD_U;
                    4'd11:   w.nd = HD_L;
                    default: w.hit = 1'b0;
                endcase
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bitmap_glyph_outline_tracer_top.sv @@
// Glyph outline tracer: row store, corner map memory and trace controller.
// Depends on bgot_pkg and bgot_emit.
//
//  channel | direction | handshake              | fields
//  command | in        | i_start high, !o_busy  | i_command, i_row_index, i_row_bits
//  result  | out       | o_strobe, one cycle    | o_point_valid .. o_box_ymax
//
// A load gives no word. The first fetch after a load builds the corner map,
// one corner a cycle. Later fetches read each map cell walked or scanned
// from memory, then evaluate it and write it back. Synchronous active-low
// reset; the map holds no defined data until the build pass. The receiver
// cannot stall; a new command is taken while the last word is on the ports.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_glyph_outline_tracer_top #(
    parameter int ROW_BITS = 18,
    parameter int ROWS     = 16,
    parameter int BASELINE = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire logic                i_command,
    input  wire logic [3:0]          i_row_index,
    input  wire logic [ROW_BITS-1:0] i_row_bits,
    output logic                     o_strobe,
    output logic                     o_point_valid,
    output logic signed [5:0]        o_delta_x,
    output logic signed [5:0]        o_delta_y,
    output logic                     o_contour_start,
    output logic [5:0]               o_point_flags,
    output logic                     o_done_res,
    output logic [7:0]               o_contour_count,
    output logic [4:0]               o_box_xmin,
    output logic [4:0]               o_box_xmax,
    output logic signed [4:0]        o_box_ymin,
    output logic signed [4:0]        o_box_ymax
);
    localparam int MAPW = ROW_BITS + 1;
    localparam int MAPH = ROWS + 1;
    localparam int MAPN = MAPW * MAPH;
    localparam int AW   = $clog2(MAPN);
    localparam int XW   = $clog2(MAPW);
    localparam int YW   = $clog2(MAPH);
    localparam int SXW  = $clog2(MAPW + 1);
    localparam int BXW  = $clog2(ROW_BITS + 3);
    localparam int RIW  = $clog2(ROWS);
    localparam int PIW  = $clog2(ROW_BITS + 2);
    localparam int DW   = $clog2(MAPW + MAPH + BASELINE + 1) + 2;

    // glyph rows and corner map
    logic [ROW_BITS-1:0] r_rows [ROWS];
    logic [3:0]          mem [MAPN];
    logic [3:0]          mem_rd;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [3:0]          mem_wd;
    logic [AW-1:0]       mem_ra;

    // control
    bgot_pkg::t_state   r_state, n_state;
    bgot_pkg::t_phase   r_phase, n_phase;
    bgot_pkg::t_heading r_heading, n_heading;
    logic [XW-1:0]  r_cx, n_cx;
    logic [YW-1:0]  r_cy, n_cy;
    logic [SXW-1:0] r_sx, n_sx;
    logic [YW-1:0]  r_sy, n_sy;
    logic [XW-1:0]  r_bx, n_bx;
    logic [YW-1:0]  r_by, n_by;
    logic [AW-1:0]  r_addr, n_addr;
    logic [7:0]     r_cnt, n_cnt;
    logic signed [DW-1:0] r_anchor_x, r_anchor_y;
    logic [ROW_BITS-1:0] r_rowa, r_rowb;
    logic [BXW-1:0] r_xmin, r_xmax;
    logic [YW-1:0]  r_ymin, r_ymax;
    logic           r_strobe;

    // emit requests
    logic           emit_pt, emit_done, emit_start, build_init, build_step;
    logic [XW-1:0]  e_x;
    logic [YW-1:0]  e_y;
    logic signed [DW-1:0] e_px, e_py;
    logic [5:0]     f_dx, f_dy, f_flags;

    // build pass corner code
    logic [ROW_BITS+1:0] wa, wb;
    logic [PIW-1:0]      pc, pp;
    logic [3:0]          bcode;
    logic                bdef;
    logic [7:0]          idx_ext;
    logic [YW:0]         by_next;
    bgot_pkg::t_walk     wk;

    assign o_busy = (r_state != bgot_pkg::ST_IDLE);

    always_comb begin
        wa      = {1'b0, r_rowa, 1'b0};
        wb      = {1'b0, r_rowb, 1'b0};
        pc      = PIW'(ROW_BITS) - PIW'(r_bx);
        pp      = pc + PIW'(1);
        bcode   = {wb[pc], wb[pp], wa[pc], wa[pp]};
        bdef    = (bcode != bgot_pkg::CODE_EMPTY) && (bcode != bgot_pkg::CODE_FULL);
        idx_ext = {4'b0, i_row_index};
        by_next = {1'b0, r_by} + (YW+1)'(1);
        wk      = bgot_pkg::walk_lookup(r_heading, mem_rd);
    end

    // next state and memory access
    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_heading = r_heading;
        n_cx = r_cx;  n_cy = r_cy;  n_sx = r_sx;  n_sy = r_sy;
        n_bx = r_bx;  n_by = r_by;  n_addr = r_addr;  n_cnt = r_cnt;
        mem_we = 1'b0;  mem_wa = r_addr;  mem_wd = 4'h0;  mem_ra = r_addr;
        emit_pt = 1'b0;  emit_done = 1'b0;  emit_start = 1'b0;
        build_init = 1'b0;  build_step = 1'b0;
        e_x = r_cx;  e_y = r_cy;
        case (r_state)
            bgot_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_command == bgot_pkg::CMD_LOAD) begin
                        n_phase = bgot_pkg::PH_NOMAP;
                    end else begin
                        case (r_phase)
                            bgot_pkg::PH_NOMAP: begin
                                build_init = 1'b1;
                                n_bx = '0;  n_by = '0;
                                n_sx = '0;  n_sy = '0;  n_cnt = '0;
                                n_state = bgot_pkg::ST_BUILD;
                            end
                            bgot_pkg::PH_SCAN:  n_state = bgot_pkg::ST_SCAN_RD;
                            bgot_pkg::PH_TRACE: n_state = bgot_pkg::ST_WALK_RD;
                            default:            emit_done = 1'b1;
                        endcase
                    end
                end
            end
            bgot_pkg::ST_BUILD: begin
                build_step = 1'b1;
                mem_we = 1'b1;
                mem_wa = AW'(AW'(r_by) * AW'(MAPW) + AW'(r_bx));
                mem_wd = bcode;
                if (r_bx == XW'(MAPW - 1)) begin
                    n_bx = '0;
                    n_by = by_next[YW-1:0];
                    if (r_by == YW'(MAPH - 1)) begin
                        n_phase = bgot_pkg::PH_SCAN;
                        n_state = bgot_pkg::ST_IDLE;
                    end
                end else begin
                    n_bx = r_bx + XW'(1);
                end
            end
            bgot_pkg::ST_SCAN_RD: begin
                if (r_sx == SXW'(MAPW)) begin
                    n_phase = bgot_pkg::PH_DONE;
                    emit_done = 1'b1;
                    n_state = bgot_pkg::ST_IDLE;
                end else begin
                    n_addr = AW'(AW'(r_sy) * AW'(MAPW) + AW'(r_sx));
                    mem_ra = n_addr;
                    n_state = bgot_pkg::ST_SCAN_EV;
                end
            end
            bgot_pkg::ST_SCAN_EV: begin
                if (r_sy == YW'(MAPH - 1)) begin
                    n_sy = '0;
                    n_sx = r_sx + SXW'(1);
                end else begin
                    n_sy = r_sy + YW'(1);
                end
                n_state = bgot_pkg::ST_SCAN_RD;
                if (mem_rd != bgot_pkg::CODE_EMPTY && mem_rd != bgot_pkg::CODE_FULL) begin
                    mem_we = 1'b1;
                    if (mem_rd == bgot_pkg::CODE_OUTER || mem_rd == bgot_pkg::CODE_HOLE) begin
                        n_heading = (mem_rd == bgot_pkg::CODE_OUTER) ? bgot_pkg::HD_R
                                                                    : bgot_pkg::HD_D;
                        n_cx = r_sx[XW-1:0];
                        n_cy = r_sy;
                        if (r_cnt != 8'hFF) n_cnt = r_cnt + 8'd1;
                        n_phase = bgot_pkg::PH_TRACE;
                        emit_pt = 1'b1;
                        emit_start = 1'b1;
                        e_x = r_sx[XW-1:0];
                        e_y = r_sy;
                        n_state = bgot_pkg::ST_IDLE;
                    end
                end
            end
            bgot_pkg::ST_WALK_RD: begin
                if ((r_heading == bgot_pkg::HD_R && r_cx == XW'(MAPW - 1)) ||
                    (r_heading == bgot_pkg::HD_D && r_cy == YW'(MAPH - 1)) ||
                    (r_heading == bgot_pkg::HD_L && r_cx == '0) ||
                    (r_heading == bgot_pkg::HD_U && r_cy == '0)) begin
                    n_phase = bgot_pkg::PH_SCAN;
                    n_state = bgot_pkg::ST_SCAN_RD;
                end else begin
                    case (r_heading)
                        bgot_pkg::HD_R: n_cx = r_cx + XW'(1);
                        bgot_pkg::HD_D: n_cy = r_cy + YW'(1);
                        bgot_pkg::HD_L: n_cx = r_cx - XW'(1);
                        default:        n_cy = r_cy - YW'(1);
                    endcase
                    n_addr = AW'(AW'(n_cy) * AW'(MAPW) + AW'(n_cx));
                    mem_ra = n_addr;
                    n_state = bgot_pkg::ST_WALK_EV;
                end
            end
            bgot_pkg::ST_WALK_EV: begin
                if (!wk.hit) begin
                    n_phase = bgot_pkg::PH_SCAN;
                    n_state = bgot_pkg::ST_SCAN_RD;
                end else begin
                    mem_we = 1'b1;
                    mem_wd = wk.nc;
                    if (wk.nd == r_heading) begin
                        n_state = bgot_pkg::ST_WALK_RD;
                    end else begin
                        n_heading = wk.nd;
                        emit_pt = 1'b1;
                        n_state = bgot_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = bgot_pkg::ST_IDLE;
        endcase
    end

    // point formatting
    assign e_px = DW'(e_x);
    assign e_py = DW'(BASELINE) - DW'(e_y);

    bgot_emit #(.DW(DW)) u_emit (
        .i_px       (e_px),
        .i_py       (e_py),
        .i_anchor_x (r_anchor_x),
        .i_anchor_y (r_anchor_y),
        .o_delta_x  (f_dx),
        .o_delta_y  (f_dy),
        .o_flags    (f_flags)
    );

    // corner map memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_rd <= mem[mem_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bgot_pkg::ST_IDLE;
            r_phase   <= bgot_pkg::PH_NOMAP;
            r_heading <= bgot_pkg::HD_R;
            r_cx <= '0;  r_cy <= '0;  r_sx <= '0;  r_sy <= '0;
            r_bx <= '0;  r_by <= '0;  r_addr <= '0;  r_cnt <= '0;
            r_anchor_x <= '0;  r_anchor_y <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;  r_phase <= n_phase;  r_heading <= n_heading;
            r_cx <= n_cx;  r_cy <= n_cy;  r_sx <= n_sx;  r_sy <= n_sy;
            r_bx <= n_bx;  r_by <= n_by;  r_addr <= n_addr;  r_cnt <= n_cnt;
            if (build_init) begin
                r_anchor_x <= '0;
                r_anchor_y <= '0;
            end else if (emit_pt) begin
                r_anchor_x <= e_px;
                r_anchor_y <= e_py;
            end
            r_strobe <= emit_pt || emit_done;
        end
    end

    // row store, build row window and bounding box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) r_rows[i] <= '0;
        end else if (r_state == bgot_pkg::ST_IDLE && i_start &&
                     i_command == bgot_pkg::CMD_LOAD && int'(idx_ext) < ROWS) begin
            r_rows[idx_ext[RIW-1:0]] <= i_row_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (build_init) begin
            r_rowa <= '0;
            r_rowb <= r_rows[0];
            r_xmin <= BXW'(ROW_BITS + 2);
            r_xmax <= '0;
            r_ymin <= YW'(ROWS);
            r_ymax <= '0;
        end else if (build_step) begin
            if (r_bx == XW'(MAPW - 1)) begin
                r_rowa <= r_rowb;
                r_rowb <= (int'(by_next) < ROWS) ? r_rows[by_next[RIW-1:0]] : '0;
            end
            if (bdef) begin
                if (BXW'(r_bx) < r_xmin) r_xmin <= BXW'(r_bx);
                if (BXW'(r_bx) > r_xmax) r_xmax <= BXW'(r_bx);
                if (r_by < r_ymin) r_ymin <= r_by;
                if (r_by > r_ymax) r_ymax <= r_by;
            end
        end
    end

    // result word
    logic signed [DW-1:0] boxy_lo, boxy_hi;
    assign boxy_lo = DW'(BASELINE) - DW'(r_ymax);
    assign boxy_hi = DW'(BASELINE) - DW'(r_ymin);

    always_ff @(posedge i_clk) begin
        if (emit_pt) begin
            o_point_valid   <= 1'b1;
            o_delta_x       <= f_dx;
            o_delta_y       <= f_dy;
            o_contour_start <= emit_start;
            o_point_flags   <= f_flags;
            o_done_res      <= 1'b0;
            o_contour_count <= n_cnt;
            o_box_xmin      <= '0;
            o_box_xmax      <= '0;
            o_box_ymin      <= '0;
            o_box_ymax      <= '0;
        end else if (emit_done) begin
            o_point_valid   <= 1'b0;
            o_delta_x       <= '0;
            o_delta_y       <= '0;
            o_contour_start <= 1'b0;
            o_point_flags   <= '0;
            o_done_res      <= 1'b1;
            o_contour_count <= r_cnt;
            o_box_xmin      <= 5'(r_xmin);
            o_box_xmax      <= 5'(r_xmax);
            o_box_ymin      <= boxy_lo[4:0];
            o_box_ymax      <= boxy_hi[4:0];
        end
    end

    assign o_strobe = r_strobe;
endmodule
`default_nettype wire

@@ rtl/bgot_emit.sv @@
// Point formatter: delta from the anchor and six-bit short-vector flag field.
// Depends on bgot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bgot_emit #(
    parameter int DW = 8
) (
    input  wire logic signed [DW-1:0] i_px,
    input  wire logic signed [DW-1:0] i_py,
    input  wire logic signed [DW-1:0] i_anchor_x,
    input  wire logic signed [DW-1:0] i_anchor_y,
    output logic [5:0]                o_delta_x,
    output logic [5:0]                o_delta_y,
    output logic [5:0]                o_flags
);
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [5:0] f;

    // deltas, then flag bits from their signs
    always_comb begin
        dx = i_px - i_anchor_x;
        dy = i_py - i_anchor_y;
        f  = bgot_pkg::FLAG_BASE;
        if (dx == '0) f = f ^ bgot_pkg::FLAG_XSAME;
        else if (dx > 0) f = f | bgot_pkg::FLAG_XPOS;
        if (dy == '0) f = f ^ bgot_pkg::FLAG_YSAME;
        else if (dy > 0) f = f | bgot_pkg::FLAG_YPOS;
        o_delta_x = dx[5:0];
        o_delta_y = dy[5:0];
        o_flags   = f;
    end
endmodule
`default_nettype wire

@@ rtl/bgot_checker.sv @@
// Port-level checks for the glyph outline tracer, bound to the top level.
// Depends on bitmap_glyph_outline_tracer_top.
`timescale 1ns / 1ps
`default_nettype none
module bgot_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       i_command,
    input wire logic       o_strobe,
    input wire logic       o_point_valid,
    input wire logic       o_done_res,
    input wire logic [4:0] o_box_xmax
);
    // a word appears only once the block is idle again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy) else $error("result word while busy");

    // a word is a point or a done word, never both
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_point_valid != o_done_res)) else $error("bad word kind");

    // point words carry no box
    a_point_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point_valid) |-> (o_box_xmax == 5'd0)) else $error("box on point");

    // a row load gives no word
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_command) |=> !o_strobe) else $error("word after load");
endmodule

bind bitmap_glyph_outline_tracer_top bgot_checker u_bgot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_command     (i_command),
    .o_strobe      (o_strobe),
    .o_point_valid (o_point_valid),
    .o_done_res    (o_done_res),
    .o_box_xmax    (o_box_xmax)
);
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for bitmap_glyph_outline_tracer_top: row loads and fetches,
// each result word checked against an in-bench outline tracer model.
// Depends on bgot_pkg and the RTL top level.
`timescale 1ns / 1ps
module testbench;

    localparam int MAP_W    = 19;
    localparam int MAP_H    = 17;
    localparam int MAP_N    = MAP_W * MAP_H;
    localparam int BASE_Y   = 12;
    localparam int N_RANDOM = 1150;
    localparam int CALM_TAIL = 150;
    localparam int HANG_LIMIT = 6000;

    typedef struct packed {
        logic              pv;
        logic signed [5:0] dx;
        logic signed [5:0] dy;
        logic              cs;
        logic [5:0]        flags;
        logic              done;
        logic [7:0]        count;
        logic [4:0]        xmin;
        logic [4:0]        xmax;
        logic signed [4:0] ymin;
        logic signed [4:0] ymax;
    } t_word;

    typedef struct {
        logic        cmd;
        logic [3:0]  row;
        logic [17:0] bits;
        bit          typed;
        t_word       exp;
    } t_cmd;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              i_command = bgot_pkg::CMD_LOAD;
    logic [3:0]        i_row_index = '0;
    logic [17:0]       i_row_bits = '0;
    logic              o_busy, o_strobe, o_point_valid, o_contour_start, o_done_res;
    logic signed [5:0] o_delta_x, o_delta_y;
    logic [5:0]        o_point_flags;
    logic [7:0]        o_contour_count;
    logic [4:0]        o_box_xmin, o_box_xmax;
    logic signed [4:0] o_box_ymin, o_box_ymax;

    bitmap_glyph_outline_tracer_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_row_index(i_row_index), .i_row_bits(i_row_bits),
        .o_strobe(o_strobe), .o_point_valid(o_point_valid), .o_delta_x(o_delta_x),
        .o_delta_y(o_delta_y), .o_contour_start(o_contour_start),
        .o_point_flags(o_point_flags), .o_done_res(o_done_res),
        .o_contour_count(o_contour_count), .o_box_xmin(o_box_xmin),
        .o_box_xmax(o_box_xmax), .o_box_ymin(o_box_ymin), .o_box_ymax(o_box_ymax)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- outline tracer model ----------------
    logic [17:0] glyph[16];
    logic [3:0]  corners[MAP_N];
    int          cur_x, cur_y, pen_x, pen_y, scan_pos, traced;
    bgot_pkg::t_heading dir;
    bgot_pkg::t_phase   phase;

    function automatic int pix(int x, int y);
        if (x < 0 || y < 0 || x >= 18 || y >= 16) return 0;
        return glyph[y][17 - x];
    endfunction

    function automatic logic [3:0] corner_of(int x, int y);
        return 4'(pix(x - 1, y - 1) | (pix(x, y - 1) << 1) |
                  (pix(x - 1, y) << 2) | (pix(x, y) << 3));
    endfunction

    function automatic t_word point_word(int x, int y, bit first);
        t_word w;
        int dx, dy;
        w = '0;
        dx = x - pen_x;
        dy = (BASE_Y - y) - pen_y;
        pen_x = x;
        pen_y = BASE_Y - y;
        w.flags = bgot_pkg::FLAG_BASE;
        if (dx == 0) w.flags ^= bgot_pkg::FLAG_XSAME;
        else if (dx > 0) w.flags |= bgot_pkg::FLAG_XPOS;
        if (dy == 0) w.flags ^= bgot_pkg::FLAG_YSAME;
        else if (dy > 0) w.flags |= bgot_pkg::FLAG_YPOS;
        w.pv = 1'b1;
        w.dx = 6'(dx);
        w.dy = 6'(dy);
        w.cs = first;
        w.count = 8'(traced);
        return w;
    endfunction

    function automatic t_word done_word();
        t_word w;
        int xl, xh, yl, yh;
        logic [3:0] c;
        xl = 20; xh = 0; yl = 16; yh = 0;
        for (int x = 0; x < MAP_W; x++)
            for (int y = 0; y < MAP_H; y++) begin
                c = corner_of(x, y);
                if (c != bgot_pkg::CODE_EMPTY && c != bgot_pkg::CODE_FULL) begin
                    if (x < xl) xl = x;
                    if (x > xh) xh = x;
                    if (y < yl) yl = y;
                    if (y > yh) yh = y;
                end
            end
        w = '0;
        w.done = 1'b1;
        w.count = 8'(traced);
        w.xmin = 5'(xl);
        w.xmax = 5'(xh);
        w.ymin = 5'(BASE_Y - yh);
        w.ymax = 5'(BASE_Y - yl);
        return w;
    endfunction

    // one cell of the walk: 0 contour ends, 1 straight on, 2 turned
    function automatic int walk_cell();
        int nx, ny;
        logic [3:0] c, left;
        bgot_pkg::t_heading nd;
        bit hit;
        nx = cur_x; ny = cur_y;
        case (dir)
            bgot_pkg::HD_R: nx++;
            bgot_pkg::HD_D: ny++;
            bgot_pkg::HD_L: nx--;
            default: ny--;
        endcase
        if (nx < 0 || ny < 0 || nx >= MAP_W || ny >= MAP_H) return 0;
        cur_x = nx;
        cur_y = ny;
        c = corners[ny * MAP_W + nx];
        hit = 1'b1;
        left = 4'h0;
        nd = dir;
        // saddles leave half the cell for a second visit
        case (dir)
            bgot_pkg::HD_R:
                if (c == 4'd4) nd = bgot_pkg::HD_D;
                else if (c == 4'd6) begin nd = bgot_pkg::HD_D; left = 4'd2; end
                else if (c == 4'd12) nd = bgot_pkg::HD_R;
                else if (c == 4'd14) nd = bgot_pkg::HD_U;
                else hit = 1'b0;
            bgot_pkg::HD_D:
                if (c == 4'd1) nd = bgot_pkg::HD_L;
                else if (c == 4'd5) nd = bgot_pkg::HD_D;
                else if (c == 4'd9) begin nd = bgot_pkg::HD_L; left = 4'd8; end
                else if (c == 4'd13) nd = bgot_pkg::HD_R;
                else hit = 1'b0;
            bgot_pkg::HD_L:
                if (c == 4'd2) nd = bgot_pkg::HD_U;
                else if (c == 4'd3) nd = bgot_pkg::HD_L;
                else if (c == 4'd6) begin nd = bgot_pkg::HD_U; left = 4'd4; end
                else if (c == 4'd7) nd = bgot_pkg::HD_D;
                else hit = 1'b0;
            default:
                if (c == 4'd8) nd = bgot_pkg::HD_R;
                else if (c == 4'd9) begin nd = bgot_pkg::HD_R; left = 4'd1; end
                else if (c == 4'd10) nd = bgot_pkg::HD_U;
                else if (c == 4'd11) nd = bgot_pkg::HD_L;
                else hit = 1'b0;
        endcase
        if (!hit) return 0;
        corners[ny * MAP_W + nx] = left;
        if (nd == dir) return 1;
        dir = nd;
        return 2;
    endfunction

    // apply one command; got tells whether a result word follows
    function automatic bit trace_command(t_cmd cm, output t_word w);
        int x, y, r;
        logic [3:0] c;
        w = '0;
        if (cm.cmd == bgot_pkg::CMD_LOAD) begin
            glyph[cm.row] = cm.bits;
            phase = bgot_pkg::PH_NOMAP;
            return 0;
        end
        if (phase == bgot_pkg::PH_NOMAP) begin
            for (y = 0; y < MAP_H; y++)
                for (x = 0; x < MAP_W; x++) corners[y * MAP_W + x] = corner_of(x, y);
            pen_x = 0; pen_y = 0; scan_pos = 0; traced = 0;
            phase = bgot_pkg::PH_SCAN;
            return 0;
        end
        if (phase == bgot_pkg::PH_TRACE) begin
            r = 1;
            while (r != 0) begin
                r = walk_cell();
                if (r == 2) begin
                    w = point_word(cur_x, cur_y, 1'b0);
                    return 1;
                end
            end
            phase = bgot_pkg::PH_SCAN;
        end
        if (phase == bgot_pkg::PH_SCAN) begin
            while (scan_pos < MAP_N) begin
                x = scan_pos / MAP_H;
                y = scan_pos % MAP_H;
                c = corners[y * MAP_W + x];
                scan_pos++;
                if (c == bgot_pkg::CODE_EMPTY || c == bgot_pkg::CODE_FULL) continue;
                corners[y * MAP_W + x] = bgot_pkg::CODE_EMPTY;
                // odd start codes are dropped untraced
                if (c == bgot_pkg::CODE_OUTER) dir = bgot_pkg::HD_R;
                else if (c == bgot_pkg::CODE_HOLE) dir = bgot_pkg::HD_D;
                else continue;
                cur_x = x;
                cur_y = y;
                if (traced < 255) traced++;
                phase = bgot_pkg::PH_TRACE;
                w = point_word(x, y, 1'b1);
                return 1;
            end
            phase = bgot_pkg::PH_DONE;
        end
        w = done_word();
        return 1;
    endfunction

    // ---------------- stimulus ----------------
    t_cmd  cmd_q[$];
    t_word words_due[$];
    int    errors = 0;
    int    taken = 0;
    int    total = 0;
    int    gap = 0;
    int    quiet = 0;
    bit    feeding = 0;

    function automatic t_cmd mk(logic c, logic [3:0] r, logic [17:0] b);
        t_cmd m;
        m.cmd = c; m.row = r; m.bits = b; m.typed = 0; m.exp = '0;
        return m;
    endfunction

    function automatic t_word empty_done();
        t_word w;
        w = '0;
        w.done = 1'b1;
        w.xmin = 5'd20;
        w.ymin = 5'sd12;
        w.ymax = -5'sd4;
        return w;
    endfunction

    task automatic build_stimulus();
        t_cmd m;
        int mode, nfetch, r0, r1, c0, c1;
        logic [17:0] rowv;
        // directed: empty glyph, then extremes, a ring (hole), a saddle pair
        cmd_q.push_back(mk(bgot_pkg::CMD_FETCH, 0, 0));
        m = mk(bgot_pkg::CMD_FETCH, 4'd15, 18'h3FFFF); m.typed = 1; m.exp = empty_done();
        cmd_q.push_back(m);
        cmd_q.push_back(m);
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd0, 18'h3FFFF));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd15, 18'h3FFFF));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd3, 18'h000E0));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd4, 18'h000A0));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd5, 18'h000E0));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd7, 18'h20001));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd10, 18'h08000));
        cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'd11, 18'h04000));
        for (int i = 0; i < 14; i++) cmd_q.push_back(mk(bgot_pkg::CMD_FETCH, 0, 0));

        // random glyphs: mostly full load-then-trace runs, some noise
        while (cmd_q.size() < N_RANDOM + 25) begin
            mode = $urandom_range(0, 3);
            r0 = $urandom_range(0, 15); r1 = $urandom_range(r0, 15);
            c0 = $urandom_range(0, 17); c1 = $urandom_range(c0, 17);
            for (int r = 0; r < 16; r++) begin
                if ($urandom_range(0, 3) == 0 && r > 3) break;
                case (mode)
                    0: rowv = 18'($urandom & $urandom & $urandom);
                    1: rowv = (r >= r0 && r <= r1) ?
                              18'(((1 << (c1 - c0 + 1)) - 1) << (17 - c1)) : 18'h0;
                    2: rowv = 18'($urandom & $urandom);
                    default: rowv = 18'($urandom);
                endcase
                cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'(r), rowv));
            end
            nfetch = $urandom_range(2, 70);
            for (int f = 0; f < nfetch; f++) begin
                if ($urandom_range(0, 29) == 0)
                    cmd_q.push_back(mk(bgot_pkg::CMD_LOAD, 4'($urandom), 18'($urandom)));
                else
                    cmd_q.push_back(mk(bgot_pkg::CMD_FETCH, 4'($urandom), 18'($urandom)));
            end
        end
        total = cmd_q.size();
    endtask

    task automatic check_field(string nm, int ev, int av);
        if (ev != av) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, nm, ev, av);
            errors++;
        end
    endtask

    // ---------------- drive, predict and check ----------------
    always @(posedge i_clk) begin
        t_word w, e;
        t_cmd  cur;
        bit    got;
        bit    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            // result word first: it never belongs to a command taken at this edge
            if (o_strobe) begin
                moved = 1'b1;
                if (words_due.size() == 0) begin
                    $display("%0t ns: result word with none expected", $time);
                    errors++;
                end else begin
                    e = words_due.pop_front();
                    check_field("point_valid", e.pv, o_point_valid);
                    check_field("delta_x", e.dx, o_delta_x);
                    check_field("delta_y", e.dy, o_delta_y);
                    check_field("contour_start", e.cs, o_contour_start);
                    check_field("point_flags", e.flags, o_point_flags);
                    check_field("done_res", e.done, o_done_res);
                    check_field("contour_count", e.count, o_contour_count);
                    check_field("box_xmin", e.xmin, o_box_xmin);
                    check_field("box_xmax", e.xmax, o_box_xmax);
                    check_field("box_ymin", e.ymin, o_box_ymin);
                    check_field("box_ymax", e.ymax, o_box_ymax);
                end
            end
            if (i_start && !o_busy) begin
                moved = 1'b1;
                cur = cmd_q.pop_front();
                got = trace_command(cur, w);
                if (got) words_due.push_back(cur.typed ? cur.exp : w);
                taken++;
                if (taken < total - CALM_TAIL && $urandom_range(0, 4) == 0)
                    gap = $urandom_range(1, 9);
            end
            quiet <= moved ? 0 : quiet + 1;
            // next command, held until taken
            if (!(i_start && o_busy)) begin
                if (gap > 0) begin
                    gap--;
                    i_start <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    i_start <= 1'b1;
                    i_command <= cmd_q[0].cmd;
                    i_row_index <= cmd_q[0].row;
                    i_row_bits <= cmd_q[0].bits;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (quiet >= HANG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("** bitmap_glyph_outline_tracer_top: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < 16; r++) glyph[r] = '0;
        for (int i = 0; i < MAP_N; i++) corners[i] = '0;
        cur_x = 0; cur_y = 0; pen_x = 0; pen_y = 0; scan_pos = 0; traced = 0;
        dir = bgot_pkg::HD_R;
        phase = bgot_pkg::PH_NOMAP;
        build_stimulus();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (taken == total && words_due.size() == 0);
        repeat (800) @(posedge i_clk);
        if (errors == 0 && words_due.size() == 0)
            $display("** bitmap_glyph_outline_tracer_top: PASSED **");
        else
            $display("** bitmap_glyph_outline_tracer_top: FAILED **");
        $finish;
    end
endmodule
